>>> src/cpfsk_tone_modulator_defines.svh
// assertion macros shared by the checker
`ifndef CPFSK_TONE_MODULATOR_DEFINES_SVH
`define CPFSK_TONE_MODULATOR_DEFINES_SVH

// same-cycle implication, masked while reset is high
`define CPFSK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpfsk check failed in the same cycle");

// next-cycle implication, active during reset as well
`define CPFSK_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cpfsk check failed one cycle later");

// next-cycle implication, masked while reset is high
`define CPFSK_ASSERT_NEXT_LIVE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpfsk check failed one cycle later outside reset");

`endif

>>> src/cpfsk_pkg.sv
`default_nettype none
package cpfsk_pkg;

   // parameter defaults
   localparam int MAX_SYMBOLS_DEF  = 128;
   localparam int NUM_SYMBOLS_DEF  = 79;
   localparam int SINE_ENTRIES_DEF = 1024;
   localparam int PHASE_BITS_DEF   = 32;

   // word field widths
   localparam int OP_W       = 2;
   localparam int SYMIDX_W   = 7;
   localparam int TONE_W     = 3;
   localparam int SAMPLE_W   = 16;

   // register widths
   localparam int CARRIER_W  = 32;
   localparam int TSTEP_W    = 24;
   localparam int SPS_W      = 20;
   localparam int SILENCE_W  = 24;
   localparam int POS_W      = 20;
   localparam int FADE_W     = 20;
   localparam int AMP_W      = 15;

   // configuration port
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;
   localparam int CSR_IW     = 3;

   // shared multiplier
   localparam int MUL_AW     = 24;
   localparam int MUL_BW     = 17;
   localparam int MUL_PW     = MUL_AW + MUL_BW;

   // operations
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_START  = 2'd1;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

   // register indexes
   localparam logic [CSR_IW-1:0] REG_CARRIER_STEP  = 3'd0;
   localparam logic [CSR_IW-1:0] REG_TONE_STEP     = 3'd1;
   localparam logic [CSR_IW-1:0] REG_SAMPLES_PER   = 3'd2;
   localparam logic [CSR_IW-1:0] REG_TUNING_MODE   = 3'd3;
   localparam logic [CSR_IW-1:0] REG_SILENT        = 3'd4;
   localparam logic [CSR_IW-1:0] REG_START_SYMBOL  = 3'd5;
   localparam logic [CSR_IW-1:0] REG_START_POS     = 3'd6;
   localparam logic [CSR_IW-1:0] REG_FADE          = 3'd7;

   // fixed-point constants
   localparam logic [AMP_W-1:0]  AMP_FULL    = 15'd32767;
   localparam logic [AMP_W-1:0]  DECAY_Q15   = 15'd32113;
   localparam logic [16:0]       POLY_A      = 17'd102944;
   localparam logic [16:0]       POLY_B      = 17'd42047;
   localparam logic [16:0]       POLY_C      = 17'd4640;
   localparam logic [16:0]       QUARTER_ONE = 17'd65536;
   localparam logic [16:0]       ROUND16     = 17'd32768;
   localparam logic [16:0]       ROUND15     = 17'd16384;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage
`default_nettype wire

>>> src/cpfsk_channels.sv
`default_nettype none

interface cpfsk_req_if
   import cpfsk_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [SYMIDX_W-1:0] symbol_index;
   logic [TONE_W-1:0]   tone_value;

   modport source (output valid, output operation, output symbol_index,
                   output tone_value, input ready);
   modport sink   (input valid, input operation, input symbol_index,
                   input tone_value, output ready);
endinterface

interface cpfsk_rsp_if
   import cpfsk_pkg::*;
;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       silent;
   logic       last;

   modport source (output valid, output sample, output silent, output last,
                   input ready);
   modport sink   (input valid, input sample, input silent, input last,
                   output ready);
endinterface

`default_nettype wire

>>> src/cpfsk_tone_modulator.sv
`default_nettype none
// Continuous-phase multi-tone FSK audio source. Load words (operation 0) fill the
// tone table, a start word (operation 1) clears the phase, restores full
// amplitude, loads the late-start counters and arms the leading silence, and each
// sample word (operation 2) returns one signed 16-bit sample. A sample word while
// idle or in the leading silence goes straight to emit; a tone sample passes the
// position, end, check, phase, decay and multiply states and the final zero
// sample leaves for emit after the check, on one shared 24x17 multiplier that runs the
// position and end products, the tone step, the amplitude decay, the five
// products of the quarter-wave sine polynomial and the amplitude scaling one
// after the other. The tone table is a synchronous memory read ahead of use;
// entries that were never loaded read as unknown. Configuration must be written
// over the csr_ port only while no word is in flight; the block does not enforce
// it. The accepted input may move on while a sample waits in the output register.
module cpfsk_tone_modulator
   import cpfsk_pkg::*;
#(
   parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
   parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF,
   parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
   parameter int PHASE_BITS   = PHASE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   cpfsk_req_if.sink              req,
   cpfsk_rsp_if.source            rsp,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   localparam int SINE_BITS = $clog2(SINE_ENTRIES);
   localparam int LOW_W     = SINE_BITS - 2;
   localparam int T_SHIFT   = 18 - SINE_BITS;
   localparam int ADDR_W    = $clog2(MAX_SYMBOLS);
   localparam int SYM_W     = $clog2((NUM_SYMBOLS + 1 > 128) ? NUM_SYMBOLS + 1 : 128);
   localparam int CMP_W     = ((SYM_W > ADDR_W) ? SYM_W : ADDR_W) + 2;
   localparam int IC_W      = SYM_W + SPS_W + 1;
   localparam int FD_W      = IC_W + 1;
   localparam int STEP_W    = TSTEP_W + TONE_W;
   localparam int SUM_W     = ((PHASE_BITS > CARRIER_W) ? PHASE_BITS : CARRIER_W) + 2;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_IC   = 4'd1;
   localparam logic [3:0] ST_END  = 4'd2;
   localparam logic [3:0] ST_CHK  = 4'd3;
   localparam logic [3:0] ST_PH   = 4'd4;
   localparam logic [3:0] ST_DEC  = 4'd5;
   localparam logic [3:0] ST_M1   = 4'd6;
   localparam logic [3:0] ST_M2   = 4'd7;
   localparam logic [3:0] ST_M3   = 4'd8;
   localparam logic [3:0] ST_M4   = 4'd9;
   localparam logic [3:0] ST_M5   = 4'd10;
   localparam logic [3:0] ST_M6   = 4'd11;
   localparam logic [3:0] ST_EMIT = 4'd12;

   localparam logic [1:0] RUN_IDLE    = 2'd0;
   localparam logic [1:0] RUN_SILENCE = 2'd1;
   localparam logic [1:0] RUN_ACTIVE  = 2'd2;

   // configuration registers
   logic [CARRIER_W-1:0]   carrier_ff,   carrier_in;
   logic [TSTEP_W-1:0]     tone_step_ff, tone_step_in;
   logic [SPS_W-1:0]       sps_ff,       sps_in;
   logic                   tuning_ff,    tuning_in;
   logic [SILENCE_W-1:0]   silent_cfg_ff, silent_cfg_in;
   logic [SYMIDX_W-1:0]    start_sym_ff, start_sym_in;
   logic [POS_W-1:0]       start_pos_ff, start_pos_in;
   logic [FADE_W-1:0]      fade_len_ff,  fade_len_in;

   // transmission state
   logic [3:0]             state_ff,    state_in;
   logic [1:0]             run_mode_ff, run_mode_in;
   logic [PHASE_BITS-1:0]  phase_ff,    phase_in;
   logic [SYM_W-1:0]       sym_ff,      sym_in;
   logic [POS_W-1:0]       pos_ff,      pos_in;
   logic [SILENCE_W-1:0]   sil_ff,      sil_in;
   logic [AMP_W-1:0]       amp_ff,      amp_in;

   // datapath
   logic [IC_W-1:0]        ic_ff,       ic_in;
   logic [TONE_W-1:0]      tone_ff,     tone_in;
   logic                   fading_ff,   fading_in;
   logic [16:0]            t2_ff,       t2_in;
   logic [MUL_PW-1:0]      mul_ff,      mul_in;
   logic [MUL_AW-1:0]      mul_a;
   logic [MUL_BW-1:0]      mul_b;

   // pending result and output register
   sample_type             res_sample_ff, res_sample_in;
   logic                   res_silent_ff, res_silent_in;
   logic                   res_last_ff,   res_last_in;
   logic                   rsp_valid_ff,  rsp_valid_in;
   sample_type             rsp_sample_ff, rsp_sample_in;
   logic                   rsp_silent_ff, rsp_silent_in;
   logic                   rsp_last_ff,   rsp_last_in;

   // tone table
   logic [TONE_W-1:0]      tone_mem [MAX_SYMBOLS];
   logic                   tab_we;
   logic [ADDR_W-1:0]      tab_waddr;
   logic [ADDR_W-1:0]      tab_raddr;
   logic [TONE_W-1:0]      rd_data_ff;

   // helpers
   logic                   csr_we;
   logic [CSR_IW-1:0]      csr_idx;
   logic [SYM_W-1:0]       isym;
   logic                   in_tab;
   logic [SINE_BITS-1:0]   sine_idx;
   logic [15:0]            t_base;
   logic [16:0]            t_val;
   logic                   neg;
   logic [SILENCE_W-1:0]   sil_dec;
   logic [SILENCE_W-1:0]   sil_start;
   logic [IC_W-1:0]        endi;
   logic [16:0]            v_sub;
   logic [MUL_PW:0]        round_sum;
   logic [16:0]            round_q;
   logic [AMP_W-1:0]       mag;
   logic [POS_W:0]         pos_inc;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];

   always_comb begin
      case (csr_idx)
         REG_CARRIER_STEP: csr_prdata = carrier_ff;
         REG_TONE_STEP:    csr_prdata = CSR_DW'(tone_step_ff);
         REG_SAMPLES_PER:  csr_prdata = CSR_DW'(sps_ff);
         REG_TUNING_MODE:  csr_prdata = CSR_DW'(tuning_ff);
         REG_SILENT:       csr_prdata = CSR_DW'(silent_cfg_ff);
         REG_START_SYMBOL: csr_prdata = CSR_DW'(start_sym_ff);
         REG_START_POS:    csr_prdata = CSR_DW'(start_pos_ff);
         REG_FADE:         csr_prdata = CSR_DW'(fade_len_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // table address and sine index follow the live counters and phase
   assign isym      = tuning_ff ? '0 : sym_ff;
   assign in_tab    = CMP_W'(isym) < CMP_W'(MAX_SYMBOLS);
   assign tab_raddr = ADDR_W'(isym);
   assign tab_waddr = ADDR_W'(req.symbol_index);

   assign sine_idx  = phase_ff[PHASE_BITS-1 -: SINE_BITS];
   assign t_base    = {sine_idx[LOW_W-1:0], {T_SHIFT{1'b0}}};
   assign t_val     = sine_idx[LOW_W] ? (QUARTER_ONE - {1'b0, t_base}) : {1'b0, t_base};
   assign neg       = sine_idx[SINE_BITS-1];

   assign sil_dec   = (sil_ff != '0) ? sil_ff - 1'b1 : sil_ff;
   assign sil_start = tuning_ff ? '0 : silent_cfg_ff;
   assign endi      = IC_W'(mul_ff);
   assign round_sum = (MUL_PW + 1)'(mul_ff) + (MUL_PW + 1)'(ROUND16);
   assign round_q   = round_sum[32:16];
   assign pos_inc   = {1'b0, pos_ff} + 1'b1;

   assign req.ready  = (state_ff == ST_IDLE);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.sample = rsp_sample_ff;
   assign rsp.silent = rsp_silent_ff;
   assign rsp.last   = rsp_last_ff;

   assign mul_in = MUL_PW'(mul_a) * MUL_PW'(mul_b);

   always_comb begin
      carrier_in    = carrier_ff;
      tone_step_in  = tone_step_ff;
      sps_in        = sps_ff;
      tuning_in     = tuning_ff;
      silent_cfg_in = silent_cfg_ff;
      start_sym_in  = start_sym_ff;
      start_pos_in  = start_pos_ff;
      fade_len_in   = fade_len_ff;

      state_in      = state_ff;
      run_mode_in   = run_mode_ff;
      phase_in      = phase_ff;
      sym_in        = sym_ff;
      pos_in        = pos_ff;
      sil_in        = sil_ff;
      amp_in        = amp_ff;
      ic_in         = ic_ff;
      tone_in       = tone_ff;
      fading_in     = fading_ff;
      t2_in         = t2_ff;
      res_sample_in = res_sample_ff;
      res_silent_in = res_silent_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_silent_in = rsp_silent_ff;
      rsp_last_in   = rsp_last_ff;
      mul_a         = '0;
      mul_b         = '0;
      tab_we        = 1'b0;
      v_sub         = '0;
      mag           = '0;

      if (csr_we) begin
         case (csr_idx)
            REG_CARRIER_STEP: carrier_in   = csr_pwdata;
            REG_TONE_STEP:    tone_step_in = csr_pwdata[TSTEP_W-1:0];
            REG_SAMPLES_PER: begin
               sps_in = (csr_pwdata[SPS_W-1:0] == '0) ? SPS_W'(1) : csr_pwdata[SPS_W-1:0];
            end
            REG_TUNING_MODE:  tuning_in     = csr_pwdata[0];
            REG_SILENT:       silent_cfg_in = csr_pwdata[SILENCE_W-1:0];
            REG_START_SYMBOL: start_sym_in  = csr_pwdata[SYMIDX_W-1:0];
            REG_START_POS:    start_pos_in  = csr_pwdata[POS_W-1:0];
            REG_FADE:         fade_len_in   = csr_pwdata[FADE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               case (req.operation)
                  OP_LOAD: begin
                     tab_we = CMP_W'(req.symbol_index) < CMP_W'(MAX_SYMBOLS);
                  end
                  OP_START: begin
                     phase_in    = '0;
                     amp_in      = AMP_FULL;
                     sil_in      = sil_start;
                     sym_in      = tuning_ff ? '0 : SYM_W'(start_sym_ff);
                     pos_in      = tuning_ff ? '0 : start_pos_ff;
                     run_mode_in = (sil_start != '0) ? RUN_SILENCE : RUN_ACTIVE;
                  end
                  OP_SAMPLE: begin
                     res_sample_in = '0;
                     res_silent_in = 1'b1;
                     res_last_in   = 1'b0;
                     case (run_mode_ff)
                        RUN_IDLE: state_in = ST_EMIT;
                        RUN_SILENCE: begin
                           sil_in = sil_dec;
                           if (sil_dec == '0) begin
                              run_mode_in = RUN_ACTIVE;
                           end
                           state_in = ST_EMIT;
                        end
                        default: state_in = ST_IC;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         ST_IC: begin
            // position index: symbol * samples per symbol
            mul_a    = MUL_AW'(sps_ff);
            mul_b    = MUL_BW'(sym_ff);
            state_in = ST_END;
         end
         ST_END: begin
            ic_in    = IC_W'(mul_ff) + IC_W'(pos_ff);
            tone_in  = in_tab ? rd_data_ff : '0;
            mul_a    = MUL_AW'(sps_ff);
            mul_b    = MUL_BW'(NUM_SYMBOLS);
            state_in = ST_END + 4'd1;
         end
         ST_CHK: begin
            if (!tuning_ff && (ic_ff >= endi)) begin
               amp_in        = '0;
               run_mode_in   = RUN_IDLE;
               res_sample_in = '0;
               res_silent_in = 1'b0;
               res_last_in   = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               // decay while ic > end - fade, kept unsigned as ic + fade > end
               fading_in = !tuning_ff &&
                           ((FD_W'(ic_ff) + FD_W'(fade_len_ff)) > FD_W'(endi));
               mul_a     = MUL_AW'(tone_step_ff);
               mul_b     = MUL_BW'(tone_ff);
               state_in  = ST_PH;
            end
         end
         ST_PH: begin
            phase_in = PHASE_BITS'(SUM_W'(phase_ff) + SUM_W'(carrier_ff) +
                                   SUM_W'(mul_ff[STEP_W-1:0]));
            mul_a    = MUL_AW'(amp_ff);
            mul_b    = MUL_BW'(DECAY_Q15);
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (fading_ff) begin
               amp_in = mul_ff[AMP_W+14:15];
            end
            mul_a    = MUL_AW'(t_val);
            mul_b    = t_val;
            state_in = ST_M1;
         end
         ST_M1: begin
            t2_in    = mul_ff[32:16];
            mul_a    = MUL_AW'(POLY_C);
            mul_b    = mul_ff[32:16];
            state_in = ST_M2;
         end
         ST_M2: begin
            v_sub    = POLY_B - mul_ff[32:16];
            mul_a    = MUL_AW'(v_sub);
            mul_b    = t2_ff;
            state_in = ST_M3;
         end
         ST_M3: begin
            v_sub    = POLY_A - mul_ff[32:16];
            mul_a    = MUL_AW'(v_sub);
            mul_b    = t_val;
            state_in = ST_M4;
         end
         ST_M4: begin
            mul_a    = MUL_AW'(AMP_FULL);
            mul_b    = mul_ff[32:16];
            state_in = ST_M5;
         end
         ST_M5: begin
            // rescale to q15 and cap at full scale
            mag      = (round_q > 17'(AMP_FULL)) ? AMP_FULL : round_q[AMP_W-1:0];
            mul_a    = MUL_AW'(amp_ff);
            mul_b    = MUL_BW'(mag);
            state_in = ST_M6;
         end
         ST_M6: begin
            mag           = AMP_W'((mul_ff + MUL_PW'(ROUND15)) >> 15);
            res_sample_in = neg ? -sample_type'({1'b0, mag}) : sample_type'({1'b0, mag});
            res_silent_in = 1'b0;
            res_last_in   = 1'b0;
            if (!tuning_ff) begin
               if (pos_inc >= {1'b0, sps_ff}) begin
                  pos_in = '0;
                  sym_in = sym_ff + 1'b1;
               end else begin
                  pos_in = pos_inc[POS_W-1:0];
               end
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_sample_ff;
               rsp_silent_in = res_silent_ff;
               rsp_last_in   = res_last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tone_mem[tab_waddr] <= req.tone_value;
      end
      rd_data_ff <= tone_mem[tab_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_ff    <= '0;
         tone_step_ff  <= '0;
         sps_ff        <= SPS_W'(1);
         tuning_ff     <= 1'b0;
         silent_cfg_ff <= '0;
         start_sym_ff  <= '0;
         start_pos_ff  <= '0;
         fade_len_ff   <= '0;
         state_ff      <= ST_IDLE;
         run_mode_ff   <= RUN_IDLE;
         phase_ff      <= '0;
         sym_ff        <= '0;
         pos_ff        <= '0;
         sil_ff        <= '0;
         amp_ff        <= AMP_FULL;
         rsp_valid_ff  <= 1'b0;
      end else begin
         carrier_ff    <= carrier_in;
         tone_step_ff  <= tone_step_in;
         sps_ff        <= sps_in;
         tuning_ff     <= tuning_in;
         silent_cfg_ff <= silent_cfg_in;
         start_sym_ff  <= start_sym_in;
         start_pos_ff  <= start_pos_in;
         fade_len_ff   <= fade_len_in;
         state_ff      <= state_in;
         run_mode_ff   <= run_mode_in;
         phase_ff      <= phase_in;
         sym_ff        <= sym_in;
         pos_ff        <= pos_in;
         sil_ff        <= sil_in;
         amp_ff        <= amp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ic_ff         <= ic_in;
      tone_ff       <= tone_in;
      fading_ff     <= fading_in;
      t2_ff         <= t2_in;
      mul_ff        <= mul_in;
      res_sample_ff <= res_sample_in;
      res_silent_ff <= res_silent_in;
      res_last_ff   <= res_last_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_silent_ff <= rsp_silent_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule
`default_nettype wire

>>> src/cpfsk_checker.sv
`default_nettype none
`include "cpfsk_tone_modulator_defines.svh"

module cpfsk_checker
   import cpfsk_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire sample_type rsp_sample,
   input wire logic       rsp_silent,
   input wire logic       rsp_last
);

   // a waiting word is not withdrawn
   `CPFSK_ASSERT_NEXT_LIVE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // reset leaves the output register empty
   `CPFSK_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // the end word is a zero sample outside the silence
   `CPFSK_ASSERT_NOW(a_last_zero, clock, reset, rsp_valid && rsp_last, (rsp_sample == '0) && !rsp_silent)

   // idle or silence words carry no audio and never end the transmission
   `CPFSK_ASSERT_NOW(a_silent_zero, clock, reset, rsp_valid && rsp_silent, (rsp_sample == '0) && !rsp_last)

endmodule

bind cpfsk_tone_modulator cpfsk_checker u_cpfsk_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_sample (rsp.sample),
   .rsp_silent (rsp.silent),
   .rsp_last   (rsp.last)
);
`default_nettype wire

>>> tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cpfsk_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 500;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum bit [1:0] {MODE_IDLE, MODE_SILENCE, MODE_TONE} tx_mode_e;

   typedef struct {
      sample_type sample;
      bit         silent;
      bit         last;
   } audio_word_t;

   class tone_scoreboard;
      // register copies
      bit [31:0]   carrier_inc;
      bit [23:0]   tone_inc;
      int unsigned sym_len;
      bit          tuning;
      int unsigned silence_len, first_symbol, first_pos, fade_len;
      // modulator state
      tx_mode_e    mode;
      bit [31:0]   phase;
      int unsigned sym_cnt, pos_cnt, silence_left, amp;
      bit [TONE_W-1:0] tone_table[MAX_SYMBOLS_DEF];
      int          sine_lut[SINE_ENTRIES_DEF];
      audio_word_t due[$];
      int unsigned errors, checked, tone_words, end_words;

      function new();
         longint unsigned u, quad, rem, t;
         int unsigned m;
         sym_len = 1;
         amp     = AMP_FULL;
         mode    = MODE_IDLE;
         for (int k = 0; k < SINE_ENTRIES_DEF; k++) begin
            u    = k * 4;
            quad = u / SINE_ENTRIES_DEF;
            rem  = u % SINE_ENTRIES_DEF;
            t    = (rem * QUARTER_ONE) / SINE_ENTRIES_DEF;
            if (quad[0]) t = QUARTER_ONE - t;
            m = quarter_wave(t);
            sine_lut[k] = quad[1] ? -int'(m) : int'(m);
         end
      endfunction

      // quarter-wave polynomial in q16, scaled to q15
      function int unsigned quarter_wave(longint unsigned t);
         longint unsigned t2, v, y;
         t2 = (t * t) >> 16;
         v  = POLY_B - ((t2 * POLY_C) >> 16);
         v  = POLY_A - ((t2 * v) >> 16);
         y  = (t * v) >> 16;
         y  = (y * 32767 + ROUND16) >> 16;
         return (y > AMP_FULL) ? AMP_FULL : y[31:0];
      endfunction

      function void write_reg(logic [CSR_IW-1:0] idx, bit [31:0] value);
         case (idx)
            REG_CARRIER_STEP: carrier_inc = value;
            REG_TONE_STEP: tone_inc = value[23:0];
            REG_SAMPLES_PER: sym_len = (value[19:0] == 0) ? 1 : value[19:0];
            REG_TUNING_MODE: tuning = value[0];
            REG_SILENT: silence_len = value[23:0];
            REG_START_SYMBOL: first_symbol = value[6:0];
            REG_START_POS: first_pos = value[19:0];
            REG_FADE: fade_len = value[19:0];
            default: ;
         endcase
      endfunction

      // returns 1 when the word ends the transmission
      function bit note_word(logic [OP_W-1:0] op, logic [SYMIDX_W-1:0] idx,
                             logic [TONE_W-1:0] tv);
         audio_word_t w;
         longint ic, end_at, fade_from;
         bit [63:0] inc;
         bit [TONE_W-1:0] tone_now;
         int unsigned row, mag;
         int s;
         w.sample = '0;
         w.silent = 1'b0;
         w.last   = 1'b0;
         if (op == OP_LOAD) begin
            if (idx < MAX_SYMBOLS_DEF) tone_table[idx] = tv;
            return 1'b0;
         end
         if (op == OP_START) begin
            phase = '0;
            amp   = AMP_FULL;
            if (tuning) begin
               silence_left = 0;
               sym_cnt      = 0;
               pos_cnt      = 0;
            end else begin
               silence_left = silence_len;
               sym_cnt      = first_symbol;
               pos_cnt      = first_pos;
            end
            mode = (silence_left != 0) ? MODE_SILENCE : MODE_TONE;
            return 1'b0;
         end
         if (op != OP_SAMPLE) return 1'b0;

         if (mode == MODE_IDLE) begin
            w.silent = 1'b1;
            due.push_back(w);
            return 1'b0;
         end
         if (mode == MODE_SILENCE) begin
            if (silence_left > 0) silence_left--;
            if (silence_left == 0) mode = MODE_TONE;
            w.silent = 1'b1;
            due.push_back(w);
            return 1'b0;
         end

         ic        = longint'(sym_cnt) * longint'(sym_len) + longint'(pos_cnt);
         end_at    = longint'(NUM_SYMBOLS_DEF) * longint'(sym_len);
         fade_from = end_at - longint'(fade_len);
         if (!tuning && ic >= end_at) begin
            amp    = 0;
            mode   = MODE_IDLE;
            w.last = 1'b1;
            due.push_back(w);
            return 1'b1;
         end

         row      = tuning ? 0 : sym_cnt;
         tone_now = (row < MAX_SYMBOLS_DEF) ? tone_table[row] : '0;
         inc      = carrier_inc;
         inc      = inc + 64'(tone_now) * tone_inc;
         phase    = phase + inc[31:0];
         if (!tuning && ic > fade_from) amp = (amp * DECAY_Q15) >> 15;

         s   = sine_lut[(64'(phase) * SINE_ENTRIES_DEF) >> PHASE_BITS_DEF];
         mag = (s < 0) ? -s : s;
         mag = (amp * mag + ROUND15) >> 15;
         s   = (s < 0) ? -int'(mag) : int'(mag);

         if (!tuning) begin
            pos_cnt++;
            if (pos_cnt >= sym_len) begin
               pos_cnt = 0;
               sym_cnt++;
            end
         end
         w.sample = s[SAMPLE_W-1:0];
         due.push_back(w);
         return 1'b0;
      endfunction

      function void check_word(sample_type smp, logic sil, logic lst);
         audio_word_t w;
         checked++;
         if (due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected sample word: sample %0d silent %0b last %0b",
                        smp, sil, lst);
            return;
         end
         w = due.pop_front();
         if (w.last) end_words++;
         else if (!w.silent) tone_words++;
         if (smp !== w.sample || sil !== w.silent || lst !== w.last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch on word %0d: expected sample %0d silent %0b last %0b, got sample %0d silent %0b last %0b",
                        checked, w.sample, w.silent, w.last, smp, sil, lst);
         end
      endfunction

      function int unsigned pending();
         return due.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   cpfsk_req_if req_ch ();
   cpfsk_rsp_if rsp_ch ();

   cpfsk_tone_modulator DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tone_scoreboard sb = new();
   bit          calm;
   bit          tx_ended;
   int unsigned words_sent;
   int unsigned settings_used;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d words still expected",
               CYCLE_LIMIT, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side back-pressure
   initial begin
      int unsigned n;
      rsp_ch.ready = 1'b1;
      forever begin
         rsp_ch.ready = 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         n = calm ? 0 : pause_len();
         if (n != 0) begin
            rsp_ch.ready = 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready)
         sb.check_word(rsp_ch.sample, rsp_ch.silent, rsp_ch.last);
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic [SYMIDX_W-1:0] idx,
                            input logic [TONE_W-1:0] tv);
      int unsigned gap;
      gap = calm ? 0 : pause_len();
      if (gap != 0) begin
         req_ch.valid        = 1'b0;
         req_ch.operation    = $urandom;
         req_ch.symbol_index = $urandom;
         req_ch.tone_value   = $urandom;
         repeat (gap) @(negedge clock);
      end
      req_ch.operation    = op;
      req_ch.symbol_index = idx;
      req_ch.tone_value   = tv;
      req_ch.valid        = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      tx_ended = sb.note_word(op, idx, tv);
      if (op != OP_UNUSED) words_sent++;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IW-1:0] idx, input bit [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_all(input bit [31:0] car, input bit [31:0] tst, input bit [31:0] sps,
                          input bit [31:0] tun, input bit [31:0] sil, input bit [31:0] ssym,
                          input bit [31:0] spos, input bit [31:0] fade);
      csr_write(REG_CARRIER_STEP, car);
      csr_write(REG_TONE_STEP, tst);
      csr_write(REG_SAMPLES_PER, sps);
      csr_write(REG_TUNING_MODE, tun);
      csr_write(REG_SILENT, sil);
      csr_write(REG_START_SYMBOL, ssym);
      csr_write(REG_START_POS, spos);
      csr_write(REG_FADE, fade);
      settings_used++;
   endtask

   // all results in, then let a trailing load or start settle
   task automatic drain();
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic play(input int unsigned cap, input bit noisy);
      int unsigned n, r;
      send_word(OP_START, $urandom, $urandom);
      n        = 0;
      tx_ended = 1'b0;
      while (!tx_ended && n < cap) begin
         if (noisy) begin
            r = $urandom_range(0, 99);
            if (r < 6) send_word(OP_UNUSED, $urandom, $urandom);
            else if (r < 10) send_word(OP_LOAD, $urandom, $urandom);
            else if (r < 12) send_word(OP_START, $urandom, $urandom);
         end
         send_word(OP_SAMPLE, $urandom, $urandom);
         n++;
      end
   endtask

   task automatic program_random();
      int unsigned r, sps, eff, hi;
      bit [31:0] car, tst, sym, pos, sil, fade;
      r   = $urandom_range(0, 99);
      car = (r < 80) ? $urandom : (r < 90) ? 32'd0 : 32'hFFFF_FFFF;
      r   = $urandom_range(0, 99);
      tst = (r < 80) ? ($urandom & 32'hFF_FFFF) : (r < 90) ? 32'd0 : 32'hFF_FFFF;
      r   = $urandom_range(0, 99);
      if (r < 65) sps = $urandom_range(1, 4);
      else if (r < 85) sps = $urandom_range(5, 40);
      else if (r < 92) sps = 0;
      else sps = $urandom_range(0, 1) ? 20'hF_FFFF : $urandom_range(1000, 20'hF_FFFF);
      eff = (sps == 0) ? 1 : sps;
      // mostly start close enough to the end that the fade and end are reached
      r  = $urandom_range(0, 99);
      hi = 60 / eff;
      if (hi < 1) hi = 1;
      if (hi > 79) hi = 79;
      if (r < 70) sym = 79 - $urandom_range(1, hi);
      else if (r < 85) sym = $urandom_range(79, 127);
      else sym = $urandom_range(0, 127);
      r = $urandom_range(0, 99);
      if (r < 60) pos = (eff > 40) ? eff - $urandom_range(1, 40) : $urandom_range(0, eff - 1);
      else if (r < 80) pos = 0;
      else pos = $urandom & 32'hF_FFFF;
      r   = $urandom_range(0, 99);
      sil = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 6) : ($urandom & 32'hFF_FFFF);
      r    = $urandom_range(0, 99);
      fade = (r < 50) ? $urandom_range(0, 60) : (r < 80) ? ($urandom & 32'hF_FFFF) : 0;
      set_all(car, tst, sps, ($urandom_range(0, 5) == 0), sil, sym, pos, fade);
   endtask

   initial begin
      int unsigned base;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.operation    = OP_LOAD;
      req_ch.symbol_index = '0;
      req_ch.tone_value   = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // idle request and an unused operation before anything is set up
      send_word(OP_SAMPLE, 7'h7F, 3'h7);
      send_word(OP_UNUSED, 7'h7F, 3'h7);
      // fill every tone entry before any tone sample reads the table
      for (int i = 0; i < MAX_SYMBOLS_DEF; i++)
         send_word(OP_LOAD, i, (i < 8) ? i : $urandom_range(0, 7));
      drain();

      // leading silence, full-range steps, fade over the whole tail
      set_all(32'hFFFF_FFFF, 32'hFF_FFFF, 3, 0, 2, 77, 1, 32'hF_FFFF);
      play(20, 1'b0);
      drain();
      // zero symbol length, start symbol past the end: immediate end
      set_all(32'd0, 32'd0, 0, 0, 0, 127, 32'hF_FFFF, 0);
      play(4, 1'b0);
      drain();
      // longest symbols, late start three samples before the end
      set_all(32'h1234_5678, 32'h12_3456, 32'hF_FFFF, 0, 0, 78, 32'hF_FFFC, 2);
      play(8, 1'b0);
      drain();
      // tuning ignores silence and end, retuned entry 0 takes effect at once
      set_all($urandom, $urandom & 32'hFF_FFFF, 5, 1, 32'hFF_FFFF, 3, 7, 10);
      play(3, 1'b0);
      send_word(OP_LOAD, 0, 3'd5);
      send_word(OP_SAMPLE, 0, 0);
      drain();
      // longest leading silence, left unfinished
      set_all(32'd0, 32'd0, 1, 0, 32'hFF_FFFF, 0, 0, 0);
      play(2, 1'b0);
      drain();

      base = words_sent;
      while (words_sent < base + RANDOM_WORDS) begin
         calm = ($urandom_range(0, 3) == 0);
         program_random();
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) send_word(OP_LOAD, $urandom, $urandom);
         play($urandom_range(20, 120), 1'b1);
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) send_word(OP_SAMPLE, $urandom, $urandom);
         drain();
      end
      calm = 1'b0;

      $display("%0d input words over %0d register settings, %0d sample words checked",
               words_sent, settings_used, sb.checked);
      $display("%0d tone samples and %0d end-of-transmission words, %0d mismatches",
               sb.tone_words, sb.end_words, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> cpfsk_tone_modulator.f
+incdir+src
src/cpfsk_pkg.sv
src/cpfsk_channels.sv
src/cpfsk_tone_modulator.sv
src/cpfsk_checker.sv
tb/sv/tb.sv
